FILE: hdl/assert_macros.svh
// Assertion macros shared by the tetrahedron inverse Jacobian RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define TIJ_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("%m: assertion failed");
`define TIJ_NEVER(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error("%m: forbidden condition seen");
`else
`define TIJ_ASSERT(lbl, prop)
`define TIJ_NEVER(lbl, expr)
`endif
`endif

FILE: hdl/tij_pkg.sv
// Shared constants and types for the tetrahedron inverse Jacobian block.
package tij_pkg;
	localparam int DET_WIDTH = 56;
	localparam int INV_WIDTH = 32;
	localparam int INV_FRAC = 16;
	localparam int COORD_INT = 4;
	localparam int DIV_LAT = INV_WIDTH + 2;
	localparam logic [INV_WIDTH-1:0] INV_POS_LIMIT = {1'b0, {(INV_WIDTH-1){1'b1}}};
	localparam logic [INV_WIDTH-1:0] INV_NEG_LIMIT = {1'b1, {(INV_WIDTH-1){1'b0}}};
	typedef logic signed [INV_WIDTH-1:0] inv_t;
	typedef logic signed [DET_WIDTH-1:0] det_t;
endpackage

FILE: hdl/tij_in_if.sv
// Vertex request channel: four tetrahedron vertices with valid and ready.
interface tij_in_if #(parameter int COORD_WIDTH = 16);
	logic valid;
	logic ready;
	logic signed [COORD_WIDTH-1:0] vertex0_x, vertex0_y, vertex0_z;
	logic signed [COORD_WIDTH-1:0] vertex1_x, vertex1_y, vertex1_z;
	logic signed [COORD_WIDTH-1:0] vertex2_x, vertex2_y, vertex2_z;
	logic signed [COORD_WIDTH-1:0] vertex3_x, vertex3_y, vertex3_z;
	modport source (output valid, output vertex0_x, vertex0_y, vertex0_z,
		vertex1_x, vertex1_y, vertex1_z, vertex2_x, vertex2_y, vertex2_z,
		vertex3_x, vertex3_y, vertex3_z, input ready);
	modport sink (input valid, input vertex0_x, vertex0_y, vertex0_z,
		vertex1_x, vertex1_y, vertex1_z, vertex2_x, vertex2_y, vertex2_z,
		vertex3_x, vertex3_y, vertex3_z, output ready);
endinterface

FILE: hdl/tij_out_if.sv
// Result request channel: determinant, singular flag and inverse Jacobian.
interface tij_out_if;
	logic valid;
	logic ready;
	tij_pkg::det_t determinant;
	logic singular;
	tij_pkg::inv_t inv_00, inv_01, inv_02;
	tij_pkg::inv_t inv_10, inv_11, inv_12;
	tij_pkg::inv_t inv_20, inv_21, inv_22;
	modport source (output valid, output determinant, singular, inv_00, inv_01, inv_02,
		inv_10, inv_11, inv_12, inv_20, inv_21, inv_22, input ready);
	modport sink (input valid, input determinant, singular, inv_00, inv_01, inv_02,
		inv_10, inv_11, inv_12, inv_20, inv_21, inv_22, output ready);
endinterface

FILE: hdl/tetrahedron_inverse_jacobian_top.sv
// Top level of the tetrahedron Jacobian determinant and inverse pipeline.
//
// Usage: the vtx channel takes one tetrahedron (twelve signed Q4.12 vertex
// coordinates) per request; the jac channel returns one request per tetrahedron
// with the exact Q.36 determinant, the singular flag and the nine inverse
// entries as saturating signed Q16.16, in the order the tetrahedra came in.
// The pipeline has four stages that form the edges, cofactors and determinant,
// two stages that prepare the division, 32 stages that produce one quotient bit
// each for all nine entries in parallel, and one output register that drives
// the jac channel.
// Throughput is one tetrahedron per cycle while the receiver does not stall the
// jac channel; every stage then accepts new work each cycle.
// Reset clears all valid bits; the data registers are not reset.
// When the receiver holds ready low with a result waiting, the whole pipeline
// freezes and vtx.ready drops; nothing is lost or repeated.
`include "assert_macros.svh"
module tetrahedron_inverse_jacobian_top #(
	parameter int COORD_WIDTH = 16
) (
	input logic clk,
	input logic arst_n,
	tij_in_if.sink vtx,
	tij_out_if.source jac
);
	localparam int EW = COORD_WIDTH + 1;
	localparam int CW = 2 * EW + 1;
	localparam int DW = EW + CW + 2;
	localparam int SH = COORD_WIDTH - tij_pkg::COORD_INT + tij_pkg::INV_FRAC;
	localparam int LAT = tij_pkg::DIV_LAT;
	localparam int XW = (DW > tij_pkg::DET_WIDTH) ? DW : tij_pkg::DET_WIDTH;

	logic adv;
	logic signed [COORD_WIDTH-1:0] coord [12];
	logic f_vld;
	logic signed [DW-1:0] det_f;
	logic signed [CW-1:0] cof_f [9];
	logic [8:0] div_vld;
	tij_pkg::inv_t div_res [9];
	logic signed [DW-1:0] det_dl_s [LAT];
	logic out_vld_q;
	logic signed [DW-1:0] det_q;
	logic singular_q;
	tij_pkg::inv_t inv_q [9];
	logic signed [XW-1:0] det_x;
	logic inv_nz;

	assign adv = !out_vld_q || jac.ready;
	assign vtx.ready = adv;

	assign coord[0] = vtx.vertex0_x;
	assign coord[1] = vtx.vertex0_y;
	assign coord[2] = vtx.vertex0_z;
	assign coord[3] = vtx.vertex1_x;
	assign coord[4] = vtx.vertex1_y;
	assign coord[5] = vtx.vertex1_z;
	assign coord[6] = vtx.vertex2_x;
	assign coord[7] = vtx.vertex2_y;
	assign coord[8] = vtx.vertex2_z;
	assign coord[9] = vtx.vertex3_x;
	assign coord[10] = vtx.vertex3_y;
	assign coord[11] = vtx.vertex3_z;

	tij_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
		.clk(clk), .arst_n(arst_n), .en(adv), .vld_in(vtx.valid),
		.coord(coord), .vld(f_vld), .det(det_f), .cof(cof_f)
	);

	for (genvar i = 0; i < 9; i++) begin : g_div
		tij_div #(.NW(CW), .DW(DW), .SH(SH)) u_div (
			.clk(clk), .arst_n(arst_n), .en(adv), .vld_in(f_vld),
			.num(cof_f[i]), .den(det_f), .vld(div_vld[i]), .res(div_res[i])
		);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			det_dl_s[0] <= det_f;
			for (int k = 1; k < LAT; k++) begin
				det_dl_s[k] <= det_dl_s[k-1];
			end
			det_q <= det_dl_s[LAT-1];
			singular_q <= (det_dl_s[LAT-1] == '0);
			inv_q <= div_res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv) begin
			out_vld_q <= div_vld[0];
		end
	end

	assign det_x = XW'(det_q);
	assign jac.valid = out_vld_q;
	assign jac.determinant = det_x[tij_pkg::DET_WIDTH-1:0];
	assign jac.singular = singular_q;
	assign jac.inv_00 = inv_q[0];
	assign jac.inv_01 = inv_q[1];
	assign jac.inv_02 = inv_q[2];
	assign jac.inv_10 = inv_q[3];
	assign jac.inv_11 = inv_q[4];
	assign jac.inv_12 = inv_q[5];
	assign jac.inv_20 = inv_q[6];
	assign jac.inv_21 = inv_q[7];
	assign jac.inv_22 = inv_q[8];

	always_comb begin
		inv_nz = 1'b0;
		for (int i = 0; i < 9; i++) begin
			inv_nz = inv_nz | (|inv_q[i]);
		end
	end

	`TIJ_ASSERT(a_singular_zero_inverse, out_vld_q && singular_q |-> !inv_nz)
	`TIJ_ASSERT(a_frozen_pipeline, !adv |=> $stable(div_vld))
	`TIJ_NEVER(a_lanes_in_step, div_vld[0] != div_vld[8])
endmodule

FILE: hdl/tij_front.sv
// Edge vectors, cofactor cross products and determinant in four pipeline stages.
module tij_front #(
	parameter int COORD_WIDTH = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic vld_in,
	input  logic signed [COORD_WIDTH-1:0] coord [12],
	output logic vld,
	output logic signed [3*COORD_WIDTH+5:0] det,
	output logic signed [2*COORD_WIDTH+2:0] cof [9]
);
	localparam int EW = COORD_WIDTH + 1;
	localparam int PW = 2 * EW;
	localparam int CW = PW + 1;
	localparam int DPW = EW + CW;
	localparam int DW = DPW + 2;

	function automatic int nxt(input int i);
		return (i == 2) ? 0 : i + 1;
	endfunction

	logic signed [EW-1:0] edge_s1 [3][3];
	logic signed [EW-1:0] e0_s2 [3];
	logic signed [CW-1:0] row_s2 [3][3];
	logic signed [CW-1:0] row_s3 [3][3];
	logic signed [DPW-1:0] dp_s3 [3];
	logic signed [CW-1:0] row_s4 [3][3];
	logic signed [DW-1:0] det_s4;
	logic vld_s1, vld_s2, vld_s3, vld_s4;
	logic signed [PW-1:0] prod_a [3][3];
	logic signed [PW-1:0] prod_b [3][3];
	logic signed [CW-1:0] cross_c [3][3];

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				prod_a[r][c] = edge_s1[nxt(r)][nxt(c)] * edge_s1[nxt(nxt(r))][nxt(nxt(c))];
				prod_b[r][c] = edge_s1[nxt(nxt(r))][nxt(c)] * edge_s1[nxt(r)][nxt(nxt(c))];
				cross_c[r][c] = {prod_a[r][c][PW-1], prod_a[r][c]}
					- {prod_b[r][c][PW-1], prod_b[r][c]};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_in;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					edge_s1[i][j] <= {coord[3*(i+1)+j][COORD_WIDTH-1], coord[3*(i+1)+j]}
						- {coord[j][COORD_WIDTH-1], coord[j]};
				end
			end
			for (int k = 0; k < 3; k++) begin
				e0_s2[k] <= edge_s1[0][k];
				dp_s3[k] <= e0_s2[k] * row_s2[0][k];
			end
			row_s2 <= cross_c;
			row_s3 <= row_s2;
			row_s4 <= row_s3;
			det_s4 <= DW'(dp_s3[0]) + DW'(dp_s3[1]) + DW'(dp_s3[2]);
		end
	end

	assign vld = vld_s4;
	assign det = det_s4;
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				cof[3*i+j] = row_s4[i][j];
			end
		end
	end
endmodule

FILE: hdl/tij_div.sv
// Pipelined restoring divider, one quotient bit per stage, with saturation.
module tij_div #(
	parameter int NW = 35,
	parameter int DW = 54,
	parameter int SH = 28
) (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic vld_in,
	input  logic signed [NW-1:0] num,
	input  logic signed [DW-1:0] den,
	output logic vld,
	output tij_pkg::inv_t res
);
	localparam int QW = tij_pkg::INV_WIDTH;
	localparam int NB = NW + SH;
	localparam int HW = NB - QW;

	logic [NW-1:0] nabs;
	logic [DW-1:0] dabs;
	logic [NW-1:0] nabs_sa;
	logic [DW-1:0] dabs_sa;
	logic neg_sa, zero_sa, vld_sa;
	logic [NB-1:0] nsh;

	logic [DW-1:0] rem_s [QW+1];
	logic [QW-1:0] lo_s [QW+1];
	logic [QW-1:0] quo_s [QW+1];
	logic [DW-1:0] dv_s [QW+1];
	logic neg_s [QW+1];
	logic zero_s [QW+1];
	logic sat_s [QW+1];
	logic [QW:0] vld_s;

	logic [QW-1:0] q;
	logic big;
	logic [QW-1:0] magn;

	assign nabs = num[NW-1] ? (~num + 1'b1) : num;
	assign dabs = den[DW-1] ? (~den + 1'b1) : den;
	assign nsh = {nabs_sa, {SH{1'b0}}};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_sa <= 1'b0;
			vld_s <= '0;
		end else if (en) begin
			vld_sa <= vld_in;
			vld_s <= {vld_s[QW-1:0], vld_sa};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nabs_sa <= nabs;
			dabs_sa <= dabs;
			neg_sa <= num[NW-1] ^ den[DW-1];
			zero_sa <= (den == '0);
			rem_s[0] <= {{(DW-HW){1'b0}}, nsh[NB-1:QW]};
			lo_s[0] <= nsh[QW-1:0];
			quo_s[0] <= '0;
			dv_s[0] <= dabs_sa;
			neg_s[0] <= neg_sa;
			zero_s[0] <= zero_sa;
			sat_s[0] <= ({{(DW-HW){1'b0}}, nsh[NB-1:QW]} >= dabs_sa);
		end
	end

	for (genvar k = 0; k < QW; k++) begin : g_bit
		logic [DW:0] t;
		logic ge;
		logic [DW:0] diff;
		assign t = {rem_s[k], lo_s[k][QW-1]};
		assign ge = (t >= {1'b0, dv_s[k]});
		assign diff = t - {1'b0, dv_s[k]};
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= ge ? diff[DW-1:0] : t[DW-1:0];
				lo_s[k+1] <= {lo_s[k][QW-2:0], 1'b0};
				quo_s[k+1] <= {quo_s[k][QW-2:0], ge};
				dv_s[k+1] <= dv_s[k];
				neg_s[k+1] <= neg_s[k];
				zero_s[k+1] <= zero_s[k];
				sat_s[k+1] <= sat_s[k];
			end
		end
	end

	assign q = quo_s[QW];
	assign big = sat_s[QW] || (neg_s[QW] ? (q > tij_pkg::INV_NEG_LIMIT)
		: (q > tij_pkg::INV_POS_LIMIT));
	assign magn = big ? (neg_s[QW] ? tij_pkg::INV_NEG_LIMIT : tij_pkg::INV_POS_LIMIT) : q;
	assign res = zero_s[QW] ? '0 : (neg_s[QW] ? (~magn + 1'b1) : magn);
	assign vld = vld_s[QW];
endmodule
